### sv/sscd_pkg.sv
package sscd_pkg;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_LOSE = 2'd1,
    MODE_DISP = 2'd2,
    MODE_BAD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNASGN = 2'd1,
    ST_NOCONN = 2'd2,
    ST_BAD    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DMAP,
    S_DLIST,
    S_REBUILD,
    S_LSCAN,
    S_LREMAP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] server_index;
    logic [7:0] connection_id;
    logic [7:0] slot;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] chosen_server;
    logic [7:0] chosen_connection;
  } out_t;

endpackage

### sv/sscd_ram.sv
module sscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### sv/slot_sharded_connection_dispatcher_top.sv
// Slot-sharded connection dispatcher. Each beat on the input is handled one at
// a time and yields one result beat. A dispatch passes through accept, slot map
// read, connection list read and result register; a dispatch whose slot has no
// usable server skips the list read. An add that gives a server its first
// connection rebuilds the slot map, which writes one slot per cycle. A lose
// scans the server's list one entry per cycle and then sweeps the slot map one
// slot per cycle. After reset a clearing pass writes every slot of the slot
// map while no input beat is taken. NUM_SLOTS must be a power of two.
module slot_sharded_connection_dispatcher_top
  import sscd_pkg::*;
#(
  parameter int NUM_SLOTS   = 256,
  parameter int MAX_SERVERS = 16,
  parameter int MAX_CONNS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_o
);

  localparam int AW   = $clog2(NUM_SLOTS);
  localparam int SW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW   = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
  localparam int CNW  = $clog2(MAX_CONNS + 1);
  localparam int NW   = $clog2(MAX_SERVERS + 1);
  localparam int IW   = ((AW + 1) > CNW) ? (AW + 1) : CNW;
  localparam int SL8  = (AW > 8) ? AW : 8;
  localparam int LAW  = SW + CW;

  state_e state_q, state_d;

  logic [4:0]     sc_q;
  logic [NW-1:0]  n_w;
  in_t            item_q, item_d;
  logic [SW-1:0]  srv_q, srv_d, ptr_q, ptr_d;
  logic [CNW-1:0] lcnt_q, lcnt_d;
  logic [IW-1:0]  idx_q, idx_d, pidx_q, pidx_d;
  logic           pend_q, pend_d, rem_q, rem_d;
  out_t           res_q, res_d, out_q;
  logic           out_valid_q;

  logic [CNW-1:0] count_q [MAX_SERVERS];
  logic [CW-1:0]  next_q  [MAX_SERVERS];

  logic           cnt_we, nxt_we;
  logic [SW-1:0]  cnt_wa, nxt_wa, cnt_ra;
  logic [CNW-1:0] cnt_wd, cnt_rd;
  logic [CW-1:0]  nxt_wd, nxt_rd;

  logic          map_we, map_re;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [SW:0]   map_wdata, map_rdata;

  logic           list_we, list_re;
  logic [LAW-1:0] list_waddr, list_raddr;
  logic [7:0]     list_wdata, list_rdata;

  logic                   accept;
  logic [SW-1:0]          srv_in, m_srv, pick, to_srv;
  logic                   srv_ok_in, add_ok, lose_ok;
  logic                   m_un, m_bad, m_empty;
  logic [MAX_SERVERS-1:0] nzn, hi;
  logic                   any_conn, found_hi, found_lo;
  logic [SW-1:0]          pick_hi, pick_lo;
  logic                   scan_issue, scan_done, sweep_issue, sweep_done;
  logic [SL8-1:0]         slot_w;
  logic [CW-1:0]          dc;
  logic [CNW-1:0]         dc1;

  sscd_ram #(.WIDTH(SW + 1), .DEPTH(2 ** AW)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  sscd_ram #(.WIDTH(8), .DEPTH(2 ** LAW)) u_list (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign n_w = (sc_q == 5'd0) ? NW'(1) :
               (32'(sc_q) > MAX_SERVERS) ? NW'(MAX_SERVERS) : NW'(sc_q);

  assign srv_in    = SW'(in_i.server_index);
  assign srv_ok_in = 32'(in_i.server_index) < 32'(n_w);
  assign slot_w    = SL8'(in_i.slot);

  assign m_un  = map_rdata[SW];
  assign m_srv = map_rdata[SW-1:0];
  assign m_bad = 32'(m_srv) >= 32'(n_w);

  assign cnt_ra  = (state_q == S_DMAP) ? m_srv : ((state_q == S_IDLE) ? srv_in : srv_q);
  assign cnt_rd  = count_q[cnt_ra];
  assign nxt_rd  = next_q[cnt_ra];
  assign m_empty = (cnt_rd == '0);
  assign add_ok  = srv_ok_in && (32'(cnt_rd) < MAX_CONNS);
  assign lose_ok = srv_ok_in && (cnt_rd != '0);

  assign dc  = (32'(nxt_rd) >= 32'(cnt_rd)) ? '0 : nxt_rd;
  assign dc1 = CNW'(dc) + CNW'(1);

  assign to_srv = (32'(srv_q) + 1 >= 32'(n_w)) ? '0 : srv_q + SW'(1);

  always_comb begin
    found_hi = 1'b0;
    found_lo = 1'b0;
    pick_hi  = '0;
    pick_lo  = '0;
    for (int s = 0; s < MAX_SERVERS; s++) begin
      nzn[s] = (count_q[s] != '0) && (s < 32'(n_w));
      hi[s]  = nzn[s] && (s >= 32'(ptr_q));
    end
    for (int s = 0; s < MAX_SERVERS; s++) begin
      if (!found_hi && hi[s]) begin
        found_hi = 1'b1;
        pick_hi  = SW'(s);
      end
      if (!found_lo && nzn[s]) begin
        found_lo = 1'b1;
        pick_lo  = SW'(s);
      end
    end
  end

  assign any_conn = |nzn;
  assign pick     = found_hi ? pick_hi : pick_lo;

  assign scan_issue  = 32'(idx_q) < 32'(lcnt_q);
  assign scan_done   = !scan_issue && !pend_q;
  assign sweep_issue = 32'(idx_q) < NUM_SLOTS;
  assign sweep_done  = !sweep_issue && !pend_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        if (idx_q == IW'(NUM_SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            MODE_ADD:  state_d = (add_ok && cnt_rd == '0) ? S_REBUILD : S_RESP;
            MODE_LOSE: state_d = lose_ok ? S_LSCAN : S_RESP;
            MODE_DISP: state_d = S_DMAP;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_DMAP: begin
        state_d = (!m_un && !m_bad && !m_empty) ? S_DLIST : S_RESP;
      end
      S_DLIST: state_d = S_RESP;
      S_REBUILD: begin
        if (idx_q == IW'(NUM_SLOTS - 1)) state_d = S_RESP;
      end
      S_LSCAN: begin
        if (scan_done) state_d = S_LREMAP;
      end
      S_LREMAP: begin
        if (sweep_done) state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    srv_d      = srv_q;
    ptr_d      = ptr_q;
    lcnt_d     = lcnt_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    pend_d     = pend_q;
    rem_d      = rem_q;
    res_d      = res_q;
    cnt_we     = 1'b0;
    cnt_wa     = srv_q;
    cnt_wd     = '0;
    nxt_we     = 1'b0;
    nxt_wa     = srv_q;
    nxt_wd     = '0;
    map_we     = 1'b0;
    map_waddr  = AW'(idx_q);
    map_wdata  = '0;
    map_re     = 1'b0;
    map_raddr  = AW'(idx_q);
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = '0;
    list_re    = 1'b0;
    list_raddr = '0;
    case (state_q)
      S_CLR: begin
        map_we = 1'b1;
        idx_d  = idx_q + IW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          item_d = in_i;
          srv_d  = srv_in;
          idx_d  = '0;
          pend_d = 1'b0;
          rem_d  = 1'b0;
          ptr_d  = '0;
          lcnt_d = cnt_rd;
          res_d  = '{status: ST_BAD, chosen_server: in_i.server_index,
                     chosen_connection: 8'd0};
          case (in_i.mode)
            MODE_ADD: begin
              if (add_ok) begin
                list_we      = 1'b1;
                list_waddr   = {srv_in, CW'(cnt_rd)};
                list_wdata   = in_i.connection_id;
                cnt_we       = 1'b1;
                cnt_wa       = srv_in;
                cnt_wd       = cnt_rd + CNW'(1);
                res_d.status = ST_OK;
              end
            end
            MODE_LOSE: begin
              if (lose_ok) res_d.status = ST_OK;
            end
            MODE_DISP: begin
              map_re    = 1'b1;
              map_raddr = slot_w[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      S_DMAP: begin
        res_d.chosen_server = 4'(m_srv);
        if (m_un) begin
          res_d.status        = ST_UNASGN;
          res_d.chosen_server = 4'd0;
        end else if (m_bad) begin
          res_d.status = ST_BAD;
        end else if (m_empty) begin
          res_d.status = ST_NOCONN;
        end else begin
          res_d.status = ST_OK;
          list_re      = 1'b1;
          list_raddr   = {m_srv, dc};
          nxt_we       = 1'b1;
          nxt_wa       = m_srv;
          nxt_wd       = (dc1 >= cnt_rd) ? '0 : CW'(dc1);
        end
      end
      S_DLIST: begin
        res_d.chosen_connection = list_rdata;
      end
      S_REBUILD: begin
        map_we    = 1'b1;
        map_wdata = {1'b0, pick};
        ptr_d     = (32'(pick) + 1 >= 32'(n_w)) ? '0 : pick + SW'(1);
        idx_d     = idx_q + IW'(1);
      end
      S_LSCAN: begin
        list_re    = scan_issue;
        list_raddr = {srv_q, CW'(idx_q)};
        pend_d     = scan_issue;
        pidx_d     = idx_q;
        if (scan_issue) idx_d = idx_q + IW'(1);
        if (pend_q) begin
          if (rem_q) begin
            list_we    = 1'b1;
            list_waddr = {srv_q, CW'(pidx_q - IW'(1))};
            list_wdata = list_rdata;
          end else if (list_rdata == item_q.connection_id) begin
            rem_d = 1'b1;
          end
        end
        if (scan_done) begin
          cnt_we = 1'b1;
          cnt_wd = lcnt_q - CNW'(1);
          nxt_we = 1'b1;
          idx_d  = '0;
          pend_d = 1'b0;
        end
      end
      S_LREMAP: begin
        map_re = sweep_issue;
        pend_d = sweep_issue;
        pidx_d = idx_q;
        if (sweep_issue) idx_d = idx_q + IW'(1);
        map_waddr = AW'(pidx_q);
        if (pend_q) begin
          if (!any_conn) begin
            map_we    = 1'b1;
            map_wdata = {1'b1, {SW{1'b0}}};
          end else if (map_rdata == {1'b0, srv_q}) begin
            map_we    = 1'b1;
            map_wdata = {1'b0, to_srv};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sc_q        <= 5'd1;
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      rem_q       <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < MAX_SERVERS; s++) begin
        count_q[s] <= '0;
        next_q[s]  <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
      ptr_q   <= ptr_d;
      if (cfg_we_i) sc_q <= cfg_wdata_i;
      if (cnt_we) count_q[cnt_wa] <= cnt_wd;
      if (nxt_we) next_q[nxt_wa] <= nxt_wd;
      if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    srv_q  <= srv_d;
    lcnt_q <= lcnt_d;
    res_q  <= res_d;
    if (state_q == S_RESP && (!out_valid_q || out_ready_i)) out_q <= res_q;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("input beat accepted but block returned to idle at once");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> 32'(cnt_wd) <= MAX_CONNS)
    else $error("connection count written beyond list capacity");

  a_map_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we && map_re |-> map_waddr != map_raddr)
    else $error("slot map read and written at the same slot");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && state_d == S_IDLE |=> out_valid_q)
    else $error("result beat not presented after completion");
`endif

endmodule

### tb/sscd_checker.sv
module sscd_checker
  import sscd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count,
  output int   pending
);

  localparam int SLOTS = 256;
  localparam int SERVERS = 16;
  localparam int CONNS = 16;
  localparam int NO_OWNER = -1;

  int         slot_owner[SLOTS];
  int         conn_cnt[SERVERS];
  int         rr_ptr[SERVERS];
  logic [7:0] conn_tab[SERVERS][CONNS];
  logic [4:0] server_cfg;
  out_t       expected_q[$];

  function automatic int active_servers();
    if (server_cfg < 1) return 1;
    if (server_cfg > SERVERS) return SERVERS;
    return server_cfg;
  endfunction

  function automatic bit has_connections(int n);
    for (int s = 0; s < n; s++) begin
      if (conn_cnt[s] != 0) return 1;
    end
    return 0;
  endfunction

  function automatic void deal_slots(int n);
    int srv;
    srv = 0;
    if (!has_connections(n)) return;
    for (int i = 0; i < SLOTS; i++) begin
      for (int k = 0; k < n && conn_cnt[srv] == 0; k++) srv = (srv + 1) % n;
      slot_owner[i] = srv;
      srv = (srv + 1) % n;
    end
  endfunction

  function automatic out_t route(in_t item);
    out_t r;
    int n, srv, cnt, w, m, c;
    bit removed;
    n = active_servers();
    srv = item.server_index;
    r.status = ST_BAD;
    r.chosen_server = item.server_index;
    r.chosen_connection = '0;
    case (mode_e'(item.mode))
      MODE_ADD: begin
        if (srv < n && conn_cnt[srv] < CONNS) begin
          conn_tab[srv][conn_cnt[srv]] = item.connection_id;
          conn_cnt[srv]++;
          if (conn_cnt[srv] == 1) deal_slots(n);
          r.status = ST_OK;
        end
      end
      MODE_LOSE: begin
        if (srv < n && conn_cnt[srv] != 0) begin
          cnt = conn_cnt[srv];
          w = 0;
          removed = 0;
          for (int i = 0; i < cnt; i++) begin
            if (!removed && conn_tab[srv][i] == item.connection_id) begin
              removed = 1;
            end else if (w < cnt - 1) begin
              conn_tab[srv][w] = conn_tab[srv][i];
              w++;
            end
          end
          conn_cnt[srv] = cnt - 1;
          rr_ptr[srv] = 0;
          if (!has_connections(n)) begin
            for (int i = 0; i < SLOTS; i++) slot_owner[i] = NO_OWNER;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_owner[i] == srv) slot_owner[i] = (srv + 1) % n;
            end
          end
          r.status = ST_OK;
        end
      end
      MODE_DISP: begin
        m = slot_owner[item.slot];
        if (m == NO_OWNER) begin
          r.status = ST_UNASGN;
          r.chosen_server = '0;
        end else begin
          r.chosen_server = m[3:0];
          if (m >= n) begin
            r.status = ST_BAD;
          end else if (conn_cnt[m] == 0) begin
            r.status = ST_NOCONN;
          end else begin
            c = rr_ptr[m];
            if (c >= conn_cnt[m]) c = 0;
            r.chosen_connection = conn_tab[m][c];
            c++;
            if (c >= conn_cnt[m]) c = 0;
            rr_ptr[m] = c;
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_owner[i] = 0;
      for (int s = 0; s < SERVERS; s++) begin
        conn_cnt[s] = 0;
        rr_ptr[s] = 0;
        for (int j = 0; j < CONNS; j++) conn_tab[s][j] = '0;
      end
      server_cfg = 5'd1;
      expected_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_i.status != want.status)
            report("status", out_i.status, want.status);
          if (out_i.chosen_server != want.chosen_server)
            report("chosen_server", out_i.chosen_server, want.chosen_server);
          if (out_i.chosen_connection != want.chosen_connection)
            report("chosen_connection", out_i.chosen_connection, want.chosen_connection);
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(route(in_i));
      if (cfg_we_i) server_cfg = cfg_wdata_i;
      pending = expected_q.size();
    end
  end

endmodule

### tb/slot_sharded_connection_dispatcher_top_test.sv
module slot_sharded_connection_dispatcher_top_test;
  import sscd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;
  int   fail_count;
  int   pending;
  int   n_use = 1;
  int   burst_left = 0;
  int   idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  slot_sharded_connection_dispatcher_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  sscd_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .in_i(in_i),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i), .out_i(out_o),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // The receiver runs free and random stretches, with one long hold-off.
  initial begin : receiver
    int cyc;
    int hold;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 3000) begin
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk_i);
      end
      if ((cyc / 150) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_server_count(logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_use = (value < 1) ? 1 : (value > 16) ? 16 : value;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send(mode_e m, int srv, int id, int slot);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_i.mode <= m;
    in_i.server_index <= srv[3:0];
    in_i.connection_id <= id[7:0];
    in_i.slot <= slot[7:0];
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic send_random();
    int pick;
    int srv;
    int id;
    mode_e m;
    pick = $urandom_range(0, 99);
    if (pick < 12) m = MODE_ADD;
    else if (pick < 20) m = MODE_LOSE;
    else if (pick < 95) m = MODE_DISP;
    else m = MODE_BAD;
    srv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n_use - 1);
    id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    send(m, srv, id, $urandom_range(0, 255));
  endtask

  initial begin : stimulus
    logic [4:0] settings[7];
    settings = '{5'd16, 5'd5, 5'd0, 5'd31, 5'd3, 5'd1, 5'd12};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_server_count(5'd16);

    send(MODE_DISP, 0, 0, 0);
    send(MODE_LOSE, 0, 7, 0);
    send(MODE_ADD, 0, 0, 0);
    send(MODE_ADD, 15, 255, 0);
    send(MODE_ADD, 15, 170, 0);
    send(MODE_DISP, 0, 0, 0);
    send(MODE_DISP, 0, 0, 255);
    send(MODE_DISP, 0, 0, 1);
    send(MODE_DISP, 0, 0, 3);
    send(MODE_ADD, 7, 85, 0);
    send(MODE_ADD, 7, 85, 0);
    send(MODE_LOSE, 7, 85, 0);
    send(MODE_LOSE, 15, 99, 0);
    send(MODE_LOSE, 3, 1, 0);
    send(MODE_BAD, 15, 255, 255);
    send(MODE_LOSE, 0, 0, 0);
    send(MODE_DISP, 0, 0, 0);
    send(MODE_DISP, 0, 0, 255);
    for (int i = 0; i < 17; i++) send(MODE_ADD, 2, i, 0);
    wait_drained();
    write_server_count(5'd1);
    send(MODE_ADD, 1, 3, 0);
    send(MODE_DISP, 0, 0, 2);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_server_count(settings[p]);
      for (int i = 0; i < 155; i++) begin
        if (i == 80) begin
          in_valid_i <= 1'b0;
          burst_left = 0;
          while (pending != 0) @(negedge clk_i);
        end
        send_random();
      end
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
